// ----- rtl/rle16_pkg.sv -----
// -----------------------------------------------------------------------------
// rle16_pkg
// Shared types and codes for the RLE16 frame decoder.
// -----------------------------------------------------------------------------
package rle16_pkg;

   localparam logic [17:0] MAX_FRAME_PIXELS = 18'd131072;
   localparam int          QUEUE_DEPTH      = 4;

   // codec_mode values
   localparam logic [1:0] CODEC_RAW = 2'd0;
   localparam logic [1:0] CODEC_RLE = 2'd1;

   // configuration register indexes
   localparam logic [1:0] REG_CODEC_MODE      = 2'd0;
   localparam logic [1:0] REG_BUFFER_PIXELS   = 2'd1;
   localparam logic [1:0] REG_EXPECTED_PIXELS = 2'd2;

   // frame status codes
   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TRUNCATED   = 3'd1;
   localparam logic [2:0] ST_ZERO_RUN    = 3'd2;
   localparam logic [2:0] ST_OVERFLOW    = 3'd3;
   localparam logic [2:0] ST_COUNT_MISM  = 3'd4;
   localparam logic [2:0] ST_GEOMETRY    = 3'd5;
   localparam logic [2:0] ST_RAW_SIZE    = 3'd6;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd7;

   // event kinds passed from front to back
   localparam logic [1:0] EV_RAW  = 2'd0;  // raw pixel pair, run of one
   localparam logic [1:0] EV_RLE  = 2'd1;  // complete count/value record
   localparam logic [1:0] EV_ERR  = 2'd2;  // error found by the front
   localparam logic [1:0] EV_MARK = 2'd3;  // last byte of a dropped frame

   typedef struct packed {
      logic [1:0]  codec_mode;
      logic [17:0] buffer_pixels;
      logic [17:0] expected_pixels;
   } rle16_cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        last;
      logic [2:0]  status;
      logic [15:0] count;
      logic [15:0] value;
   } rle16_event_type;

endpackage

// ----- rtl/rle16_front.sv -----
// -----------------------------------------------------------------------------
// rle16_front
// Byte assembler: builds raw pairs and RLE records, flags front-side errors.
// -----------------------------------------------------------------------------
module rle16_front import rle16_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  rle16_cfg_type   cfg,
   input  logic            byte_valid,
   input  logic [7:0]      stored_byte,
   input  logic            last_byte,
   output logic            ev_push,
   output rle16_event_type ev_data
);

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] held_ff, held_in;
   logic        drop_ff, drop_in;

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      drop_in  = drop_ff;
      ev_push  = 1'b0;
      ev_data  = '0;
      ev_data.last = last_byte;
      if (byte_valid) begin
         if (drop_ff) begin
            if (last_byte) begin
               ev_push      = 1'b1;
               ev_data.kind = EV_MARK;
               drop_in      = 1'b0;
            end
         end else if (cfg.expected_pixels != cfg.buffer_pixels) begin
            ev_push        = 1'b1;
            ev_data.kind   = EV_ERR;
            ev_data.status = ST_GEOMETRY;
            drop_in        = !last_byte;
         end else if (cfg.codec_mode != CODEC_RAW && cfg.codec_mode != CODEC_RLE) begin
            ev_push        = 1'b1;
            ev_data.kind   = EV_ERR;
            ev_data.status = ST_UNSUPPORTED;
            drop_in        = !last_byte;
         end else if (cfg.codec_mode == CODEC_RAW) begin
            if (phase_ff == 2'd0) begin
               held_in  = {16'd0, stored_byte};
               phase_in = 2'd1;
               if (last_byte) begin
                  ev_push        = 1'b1;
                  ev_data.kind   = EV_ERR;
                  ev_data.status = ST_RAW_SIZE;
               end
            end else begin
               ev_push       = 1'b1;
               ev_data.kind  = EV_RAW;
               ev_data.count = 16'd1;
               ev_data.value = {stored_byte, held_ff[7:0]};
               phase_in      = 2'd0;
               held_in       = '0;
            end
         end else begin
            if (phase_ff != 2'd3) begin
               case (phase_ff)
                  2'd0:    held_in = {held_ff[23:8], stored_byte};
                  2'd1:    held_in = {held_ff[23:16], stored_byte, held_ff[7:0]};
                  default: held_in = {stored_byte, held_ff[15:0]};
               endcase
               phase_in = phase_ff + 2'd1;
               if (last_byte) begin
                  ev_push        = 1'b1;
                  ev_data.kind   = EV_ERR;
                  ev_data.status = ST_TRUNCATED;
               end
            end else begin
               ev_push       = 1'b1;
               ev_data.kind  = EV_RLE;
               ev_data.count = held_ff[15:0];
               ev_data.value = {stored_byte, held_ff[23:16]};
               phase_in      = 2'd0;
               held_in       = '0;
            end
         end
         // any event or the end of the frame restarts assembly
         if (last_byte || (ev_push && ev_data.kind == EV_ERR)) begin
            phase_in = 2'd0;
            held_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         held_ff  <= '0;
         drop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         drop_ff  <= drop_in;
      end
   end

endmodule

// ----- rtl/rle16_fifo.sv -----
// -----------------------------------------------------------------------------
// rle16_fifo
// Short event queue between the byte assembler and the run generator.
// -----------------------------------------------------------------------------
module rle16_fifo import rle16_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rle16_event_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            pop_valid,
   output rle16_event_type pop_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   rle16_event_type mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]     count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/rle16_back.sv -----
// -----------------------------------------------------------------------------
// rle16_back
// Run generator: pixel accounting, capacity and count checks, result register.
// -----------------------------------------------------------------------------
module rle16_back import rle16_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  rle16_cfg_type   cfg,
   input  logic            ev_valid,
   input  rle16_event_type ev_data,
   output logic            ev_pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [55:0]     rsp_tdata,
   output logic [3:0]      rsp_tuser,
   output logic            rsp_tlast
);

   logic [17:0] pw_ff, pw_in;
   logic        err_ff, err_in;
   logic        out_valid_ff;
   logic [55:0] out_data_ff;
   logic [3:0]  out_user_ff;
   logic        out_last_ff;

   logic        out_free;
   logic [17:0] cap;
   logic [18:0] rle_sum;
   logic        run;
   logic        done;
   logic [2:0]  status;
   logic [15:0] r_value;
   logic [15:0] r_length;
   logic [16:0] r_start;
   logic        emit;

   assign out_free = !out_valid_ff || rsp_tready;
   assign ev_pop   = ev_valid && out_free;
   assign cap      = (cfg.buffer_pixels < MAX_FRAME_PIXELS) ? cfg.buffer_pixels
                                                             : MAX_FRAME_PIXELS;
   assign rle_sum  = {1'b0, pw_ff} + {3'b000, ev_data.count};

   always_comb begin
      pw_in    = pw_ff;
      err_in   = err_ff;
      run      = 1'b0;
      status   = ST_OK;
      r_value  = '0;
      r_length = '0;
      r_start  = '0;
      done     = 1'b0;
      emit     = 1'b0;
      if (ev_pop) begin
         if (err_ff) begin
            // drop until the end of the frame
            if (ev_data.last) begin
               err_in = 1'b0;
               pw_in  = '0;
            end
         end else begin
            case (ev_data.kind)
               EV_ERR: begin
                  status = ev_data.status;
               end
               EV_RAW: begin
                  if (pw_ff >= cap) begin
                     status = ST_RAW_SIZE;
                  end else begin
                     run   = 1'b1;
                     pw_in = pw_ff + 18'd1;
                     if (ev_data.last && pw_in != cfg.buffer_pixels) status = ST_RAW_SIZE;
                  end
               end
               EV_RLE: begin
                  if (ev_data.count == '0) begin
                     status = ST_ZERO_RUN;
                  end else if (rle_sum > {1'b0, cap}) begin
                     status = ST_OVERFLOW;
                  end else begin
                     run   = 1'b1;
                     pw_in = rle_sum[17:0];
                     if (ev_data.last && pw_in != cfg.expected_pixels) status = ST_COUNT_MISM;
                  end
               end
               default: begin
               end
            endcase
            if (run) begin
               r_value  = ev_data.value;
               r_length = ev_data.count;
               r_start  = pw_ff[16:0];
            end
            done = ev_data.last || (status != ST_OK);
            emit = (run || done) && (ev_data.kind != EV_MARK);
            if (done) begin
               pw_in = '0;
               if (status != ST_OK && !ev_data.last) err_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_data_ff <= {7'd0, r_start, r_length, r_value};
         out_user_ff <= {status, run};
         out_last_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff        <= '0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pw_ff  <= pw_in;
         err_ff <= err_in;
         if (emit) out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   a_pw_bound: assert property (@(posedge clock) disable iff (reset)
      pw_ff <= MAX_FRAME_PIXELS)
      else $error("pixel count passed frame limit");

   a_err_done: assert property (@(posedge clock) disable iff (reset)
      emit && status != ST_OK |-> done)
      else $error("error result without frame end");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      ev_pop && err_ff && !ev_data.last |=> err_ff)
      else $error("drop mode left before frame end");

   a_no_emit_drop: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> !emit)
      else $error("result produced while dropping");

endmodule

// ----- rtl/rle16_frame_decoder_core.sv -----
// -----------------------------------------------------------------------------
// rle16_frame_decoder_core
// Streaming RLE16 / raw RGB565 frame decoder producing run descriptors.
// -----------------------------------------------------------------------------
// Takes one stored frame byte per cycle while the event queue has room and
// returns one run descriptor per complete record (RLE16) or byte pair (raw),
// plus a frame end with status on the last byte or the first error. The
// byte assembler and the run generator sit on either side of a four-entry
// event queue. A byte's event is written into the queue, and the run
// generator pops it into the result register once that register is free;
// the descriptor transfers from there. Output stalls back up through the
// queue and drop req_tready only once all four entries are taken. Bytes
// after an error are swallowed until tlast.
// Configuration writes are taken every cycle and must land while idle.
// -----------------------------------------------------------------------------
module rle16_frame_decoder_core import rle16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stored_byte
   input  logic        req_tlast,   // last_byte
   // run descriptors
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] pixel_value, [31:16] run_length,
                                    // [48:32] start_pixel, [55:49] zero
   output logic [3:0]  rsp_tuser,   // [0] run_valid, [3:1] status
   output logic        rsp_tlast,   // frame_done
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [17:0] csr_data
);

   rle16_cfg_type   cfg_ff;
   rle16_event_type front_ev;
   rle16_event_type back_ev;
   logic            front_push;
   logic            q_full;
   logic            q_valid;
   logic            q_pop;
   logic            byte_accept;

   assign csr_ready   = 1'b1;
   assign req_tready  = !q_full;
   assign byte_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.codec_mode      <= CODEC_RLE;
         cfg_ff.buffer_pixels   <= '0;
         cfg_ff.expected_pixels <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CODEC_MODE:      cfg_ff.codec_mode      <= csr_data[1:0];
            REG_BUFFER_PIXELS:   cfg_ff.buffer_pixels   <= csr_data;
            REG_EXPECTED_PIXELS: cfg_ff.expected_pixels <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rle16_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .byte_valid  (byte_accept),
      .stored_byte (req_tdata),
      .last_byte   (req_tlast),
      .ev_push     (front_push),
      .ev_data     (front_ev)
   );

   rle16_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_ev),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (back_ev)
   );

   rle16_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .ev_valid   (q_valid),
      .ev_data    (back_ev),
      .ev_pop     (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- dv/tb.sv -----
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the RLE16 frame decoder core.
// Streams stored frame bytes in RLE16, raw and unsupported modes under
// several register settings. A scoreboard predicts every run descriptor and
// frame end and compares them with what the core returns. Gaps on the input
// side and stalls on the output side are random except while quiet is set.
// -----------------------------------------------------------------------------
module tb;
   import rle16_pkg::*;

   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          ITEM_TARGET   = 1550;
   localparam int          SETTLE_CYCLES = 10;
   localparam logic [1:0]  CODEC_SPARE_LO = 2'd2;
   localparam logic [1:0]  CODEC_SPARE_HI = 2'd3;
   localparam logic [1:0]  REG_SPARE      = 2'd3;
   localparam logic [17:0] PIXELS_ALL_ONES = 18'h3FFFF;

   typedef struct packed {
      logic        run;
      logic [15:0] value;
      logic [15:0] length;
      logic [16:0] start;
      logic        done;
      logic [2:0]  status;
   } run_desc_type;

   class frame_scoreboard;
      logic [1:0]   codec;
      logic [17:0]  buf_px;
      logic [17:0]  exp_px;
      logic [1:0]   phase;
      logic [23:0]  held;
      int unsigned  written;
      bit           dropping;
      run_desc_type runs_due[$];
      int           mismatches;
      int           runs_seen;
      int           ends_seen;
      int           bytes_seen;
      int           bytes_decoded;
      bit [7:0]     status_seen;

      function new();
         codec    = CODEC_RLE;
         buf_px   = '0;
         exp_px   = '0;
         dropping = 1'b0;
         clear_frame();
      endfunction

      function void clear_frame();
         phase   = '0;
         held    = '0;
         written = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [17:0] val);
         case (idx)
            REG_CODEC_MODE:      codec  = val[1:0];
            REG_BUFFER_PIXELS:   buf_px = val;
            REG_EXPECTED_PIXELS: exp_px = val;
            default: ;
         endcase
      endfunction

      // Note one accepted byte and queue the descriptor it causes, if any.
      function void note_byte(logic [7:0] b, logic last);
         int unsigned  cap;
         int unsigned  count;
         logic [2:0]   st;
         run_desc_type r;
         cap = (buf_px < MAX_FRAME_PIXELS) ? buf_px : MAX_FRAME_PIXELS;
         r   = '0;
         st  = ST_OK;
         bytes_seen++;
         if (dropping) begin
            if (last) begin
               dropping = 1'b0;
               clear_frame();
            end
            return;
         end
         bytes_decoded++;
         if (exp_px != buf_px) begin
            st = ST_GEOMETRY;
         end else if (codec != CODEC_RAW && codec != CODEC_RLE) begin
            st = ST_UNSUPPORTED;
         end else if (codec == CODEC_RAW) begin
            if (phase == 0) begin
               held  = {16'h0, b};
               phase = 2'd1;
               if (last) st = ST_RAW_SIZE;
            end else begin
               phase = 2'd0;
               if (written >= cap) begin
                  st = ST_RAW_SIZE;
               end else begin
                  r.run    = 1'b1;
                  r.value  = {b, held[7:0]};
                  r.length = 16'd1;
                  r.start  = written[16:0];
                  written++;
                  if (last && written != buf_px) st = ST_RAW_SIZE;
               end
               held = '0;
            end
         end else if (phase < 3) begin
            held  = held | (24'(b) << (8 * phase));
            phase = phase + 2'd1;
            if (last) st = ST_TRUNCATED;
         end else begin
            count = held[15:0];
            phase = 2'd0;
            if (count == 0) begin
               st = ST_ZERO_RUN;
            end else if (written + count > cap) begin
               st = ST_OVERFLOW;
            end else begin
               r.run    = 1'b1;
               r.value  = {b, held[23:16]};
               r.length = count[15:0];
               r.start  = written[16:0];
               written += count;
               if (last && written != exp_px) st = ST_COUNT_MISM;
            end
            held = '0;
         end
         r.done   = last || (st != ST_OK);
         r.status = st;
         if (!r.run && !r.done) return;
         runs_due.push_back(r);
         if (r.done) begin
            clear_frame();
            if (st != ST_OK && !last) dropping = 1'b1;
         end
      endfunction

      function void report(string what, run_desc_type want, run_desc_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s", what);
            $display("   expected run=%0d value=%h len=%0d start=%0d done=%0d status=%0d",
                     want.run, want.value, want.length, want.start, want.done, want.status);
            $display("   actual   run=%0d value=%h len=%0d start=%0d done=%0d status=%0d",
                     got.run, got.value, got.length, got.start, got.done, got.status);
         end
      endfunction

      // Compare one returned descriptor with the oldest one due.
      function void check_result(logic [55:0] data, logic [3:0] user, logic last);
         run_desc_type got;
         run_desc_type want;
         got.run    = user[0];
         got.value  = data[15:0];
         got.length = data[31:16];
         got.start  = data[48:32];
         got.done   = last;
         got.status = user[3:1];
         if (got.run) runs_seen++;
         if (got.done) begin
            ends_seen++;
            status_seen[got.status] = 1'b1;
         end
         if (runs_due.size() == 0) begin
            report("descriptor with none due", '0, got);
            return;
         end
         want = runs_due.pop_front();
         if (got !== want) report("descriptor mismatch", want, got);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [17:0] csr_data;

   frame_scoreboard sb = new();
   bit              quiet;
   int              cycles = 0;
   logic [7:0]      frame_q[$];

   rle16_frame_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Mostly short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (quiet || $urandom_range(0, 99) < 70) begin
            rsp_tready <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   // Hold the input until every descriptor due has come back, then settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.runs_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [17:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic configure(input logic [1:0] mode, input logic [17:0] bufp,
                            input logic [17:0] expp);
      drain();
      csr_write(REG_CODEC_MODE, {16'h0, mode});
      csr_write(REG_BUFFER_PIXELS, bufp);
      csr_write(REG_EXPECTED_PIXELS, expp);
      if ($urandom_range(0, 7) == 0) csr_write(REG_SPARE, 18'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_pixel();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic void add_record(int unsigned count, logic [15:0] value);
      frame_q.push_back(count[7:0]);
      frame_q.push_back(count[15:8]);
      frame_q.push_back(value[7:0]);
      frame_q.push_back(value[15:8]);
   endfunction

   function automatic void add_junk();
      frame_q.delete();
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
   endfunction

   // Split the frame's pixels into records, then maybe break the frame.
   function automatic void build_rle_frame();
      int unsigned counts[$];
      int unsigned n, left, lim, c, k, i;
      n    = sb.buf_px;
      left = n;
      while (left > 0 && counts.size() < 10) begin
         lim = (left > 65535) ? 65535 : left;
         if (lim > n / 2 + 1) lim = n / 2 + 1;
         c = $urandom_range(1, lim);
         counts.push_back(c);
         left -= c;
      end
      while (left > 0) begin
         c = (left > 65535) ? 65535 : left;
         counts.push_back(c);
         left -= c;
      end
      if (counts.size() == 0) counts.push_back($urandom_range(0, 3));
      k = $urandom_range(0, 99);
      i = counts.size() - 1;
      if (k >= 55 && k < 65) begin
         if (counts[i] > 1) counts[i] -= $urandom_range(1, counts[i] - 1);
         else if (counts.size() > 1) void'(counts.pop_back());
      end else if (k >= 65 && k < 73) begin
         i = $urandom_range(0, counts.size() - 1);
         if (counts[i] < 65535) counts[i] += $urandom_range(1, 65535 - counts[i]);
      end else if (k >= 73 && k < 80) begin
         counts[$urandom_range(0, counts.size() - 1)] = 0;
      end
      frame_q.delete();
      foreach (counts[j]) add_record(counts[j], rand_pixel());
      if (k >= 80 && k < 90) repeat ($urandom_range(1, 3)) void'(frame_q.pop_back());
      else if (k >= 90) add_junk();
   endfunction

   function automatic void build_raw_frame();
      int unsigned n, pairs, k;
      logic [15:0] px;
      n     = sb.buf_px;
      pairs = (n > 48) ? $urandom_range(1, 48) : n;
      k     = $urandom_range(0, 99);
      if (k >= 70 && k < 80) pairs += $urandom_range(1, 2);
      else if (k >= 80 && k < 90 && pairs > 1) pairs--;
      if (pairs == 0) pairs = 1;
      frame_q.delete();
      repeat (pairs) begin
         px = rand_pixel();
         frame_q.push_back(px[7:0]);
         frame_q.push_back(px[15:8]);
      end
      if (k >= 60 && k < 70) void'(frame_q.pop_back());
      else if (k >= 90) add_junk();
   endfunction

   task automatic random_config();
      int unsigned r, s;
      logic [1:0]  mode;
      logic [17:0] n, e;
      r = $urandom_range(0, 99);
      if (r < 35) mode = CODEC_RAW;
      else if (r < 88) mode = CODEC_RLE;
      else mode = 2'($urandom_range(CODEC_SPARE_LO, CODEC_SPARE_HI));
      s = $urandom_range(0, 99);
      if (s < 5) n = '0;
      else if (s < 80) n = 18'($urandom_range(1, 40));
      else if (s < 90) n = 18'($urandom_range(41, 2000));
      else if (s < 95) n = MAX_FRAME_PIXELS;
      else n = 18'($urandom_range(MAX_FRAME_PIXELS + 1, PIXELS_ALL_ONES));
      e = n;
      if ($urandom_range(0, 99) < 6) e = n ^ (18'd1 << $urandom_range(0, 17));
      configure(mode, n, e);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_CODEC_MODE;
      csr_data   <= '0;
      quiet       = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: capacity is zero, so any real record overflows.
      frame_q = '{8'h01, 8'h00, 8'h00, 8'h00, 8'hFF};
      send_frame();

      // Full-size frame built mostly from maximum-length runs, then a zero-length run.
      configure(CODEC_RLE, MAX_FRAME_PIXELS, MAX_FRAME_PIXELS);
      frame_q.delete();
      add_record(65535, 16'hFFFF);
      add_record(65535, 16'h0000);
      add_record(2, 16'h1234);
      send_frame();
      frame_q.delete();
      add_record(0, 16'hABCD);
      send_frame();

      // Buffer above the frame limit; frame cut after one byte.
      configure(CODEC_RLE, PIXELS_ALL_ONES, PIXELS_ALL_ONES);
      frame_q = '{8'hA5};
      send_frame();

      // Geometry error mid-frame, then the rest is dropped.
      configure(CODEC_RAW, 18'd1, 18'd2);
      frame_q = '{8'h5A, 8'h00};
      send_frame();

      configure(CODEC_SPARE_HI, 18'd7, 18'd7);
      frame_q = '{8'h3C};
      send_frame();

      // Raw: one good pair, then an odd-length frame.
      configure(CODEC_RAW, 18'd1, 18'd1);
      frame_q = '{8'hFF, 8'h00};
      send_frame();
      frame_q = '{8'h80};
      send_frame();

      while (sb.bytes_seen < ITEM_TARGET) begin
         random_config();
         quiet = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 5)) begin
            if (sb.codec == CODEC_RAW) build_raw_frame();
            else build_rle_frame();
            send_frame();
         end
      end
      quiet = 1'b0;
      drain();

      $display("covered %0d bytes (%0d decoded), %0d runs returned, %0d frame ends",
               sb.bytes_seen, sb.bytes_decoded, sb.runs_seen, sb.ends_seen);
      $display("frame status codes observed (bit per code): %b", sb.status_seen);
      if (sb.runs_due.size() != 0)
         $display("%0d descriptors never returned", sb.runs_due.size());
      if (sb.mismatches > 0) $display("%0d descriptor mismatches", sb.mismatches);
      if (sb.mismatches == 0 && sb.runs_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/rle16_pkg.sv
rtl/rle16_front.sv
rtl/rle16_fifo.sv
rtl/rle16_back.sv
rtl/rle16_frame_decoder_core.sv
dv/tb.sv
